// ===== rtl/core/bpa_pkg.sv =====
// shared types and constants for the bitmap page allocator
`default_nettype none
package bpa_pkg;

	localparam int ADDR_W  = 48;
	localparam int CNT_W   = 17;
	localparam int START_W = 16;
	localparam int ACT_W   = 2;
	localparam int WORD_W  = 64;
	localparam int BIT_W   = 6;
	localparam int FLIP_W  = 7;

	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC     = 2'd0,
		ACT_FREE      = 2'd1,
		ACT_MARK_FREE = 2'd2,
		ACT_MARK_USED = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SETUP,
		S_START,
		S_SCAN,
		S_WALK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [BIT_W-1:0]  lo;
		logic [BIT_W:0]    hi_excl;
		logic              set;
	} word_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] new_word;
		logic [FLIP_W-1:0] flips;
		logic              all_ones;
		logic              all_zeros;
		logic              bit_at_lo;
	} word_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/bitmap_page_allocator_unit.sv =====
// top level: bitmap first-fit page allocator with sequencer and result register
`default_nettype none
// Request timing: after reset the bitmap is filled with used marks, one 64-page word per cycle
// (ceil(min(NUM_PAGES,65536)/64) words, 1024 at the default size) and no request is taken
// meanwhile; configuration writes are taken at any time. A request then runs on one shared
// word unit against a single-port-read bitmap memory: a setup state and a start state, then for
// an allocation a scan of one fully used or fully free 64-page word per cycle and one page per
// cycle inside a mixed word, followed by marking the found run used one word per cycle. Free
// and mark requests walk the 64-page words they touch one per cycle. The result passes through
// the done state into an output register, so a new request is taken while it waits.
module bitmap_page_allocator_unit #(
	parameter int NUM_PAGES  = 65536,
	parameter int PAGE_BYTES = 4096,
	parameter int ADDR_BITS  = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [bpa_pkg::ACT_W-1:0]   action,
	input  logic [bpa_pkg::ADDR_W-1:0]  address,
	input  logic [bpa_pkg::ADDR_W-1:0]  length,
	input  logic [bpa_pkg::CNT_W-1:0]   req_pages,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ok,
	output logic [bpa_pkg::START_W-1:0] start_page,
	output logic [bpa_pkg::CNT_W-1:0]   pages_left,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bpa_pkg::CNT_W-1:0]   cfg_data
);
	import bpa_pkg::*;

	localparam int MAP_CAP   = 1 << (CNT_W - 1);
	localparam int MAP_PAGES = (NUM_PAGES > MAP_CAP) ? MAP_CAP : NUM_PAGES;
	localparam int WORDS     = (MAP_PAGES + WORD_W - 1) / WORD_W;
	localparam int WIDX      = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PB_SHIFT  = $clog2(PAGE_BYTES);
	localparam int AB        = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int SUM_W     = CNT_W + 1;
	localparam int FE_W      = ADDR_W + 1;
	localparam int SP_W      = ADDR_W + 2;
	localparam logic [ADDR_W-1:0] AMASK = (AB >= ADDR_W) ? {ADDR_W{1'b1}} :
		((ADDR_W'(1) << AB) - ADDR_W'(1));
	localparam logic [CNT_W-1:0] LIM_MAX = CNT_W'(MAP_PAGES);

	state_t state_q, state_d;
	action_t act_q;
	logic [ADDR_W-1:0] addr_q, len_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SP_W-1:0]   span_q;
	logic [CNT_W-1:0]  p_q, p_d, end_q, end_d, run_q, run_d, rs_q, rs_d;
	logic [CNT_W-1:0]  fc_q, fc_d, total_q;
	logic              res_ok_q, res_ok_d;
	logic [START_W-1:0] res_start_q, res_start_d;
	logic [WIDX-1:0]   init_q, init_d;
	logic [FLIP_W-1:0] flips_s1;
	logic              flips_v_s1, flips_v_d;
	logic              out_valid_q, ok_q, load_out;
	logic [START_W-1:0] start_page_q;
	logic [CNT_W-1:0]  pages_left_q;

	logic              wr_en;
	logic [WIDX-1:0]   wr_addr;
	logic [WORD_W-1:0] wr_data, rd_data;
	word_req_t         wreq;
	word_res_t         wres;

	logic              accept, is_mark, same_word, fits, found;
	logic [CNT_W-1:0]  lim, st, found_st, next_base, free_end, mark_end, flip_fc, last_pg;
	logic [ADDR_W-1:0] first_pg;
	logic [FE_W-1:0]   fsum;
	logic [SP_W-1:0]   mark_endp;
	logic [SUM_W-1:0]  fc_add, flip_sum, run64, p64;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign lim       = (total_q > LIM_MAX) ? LIM_MAX : total_q;
	assign is_mark   = (act_q == ACT_MARK_FREE) || (act_q == ACT_MARK_USED);
	assign first_pg  = addr_q >> PB_SHIFT;
	assign fsum      = FE_W'(first_pg) + FE_W'(cnt_q);
	assign free_end  = (fsum > FE_W'(lim)) ? lim : fsum[CNT_W-1:0];
	assign mark_endp = span_q >> PB_SHIFT;
	assign mark_end  = (mark_endp > SP_W'(lim)) ? lim : mark_endp[CNT_W-1:0];
	assign fc_add    = SUM_W'(fc_q) + SUM_W'(cnt_q);
	assign last_pg   = end_q - CNT_W'(1);
	assign same_word = (last_pg[CNT_W-1:BIT_W] == p_q[CNT_W-1:BIT_W]);
	assign next_base = {p_q[CNT_W-1:BIT_W], {BIT_W{1'b0}}} + CNT_W'(WORD_W);
	assign run64     = SUM_W'(run_q) + SUM_W'(WORD_W);
	assign p64       = SUM_W'(p_q) + SUM_W'(WORD_W);
	assign fits      = (p_q[BIT_W-1:0] == '0) && (p64 <= SUM_W'(lim));
	assign st        = (run_q == '0) ? p_q : rs_q;
	assign flip_sum  = SUM_W'(fc_q) + SUM_W'(flips_s1);

	always_comb begin
		if (act_q == ACT_MARK_USED) begin
			flip_fc = (fc_q > CNT_W'(flips_s1)) ? (fc_q - CNT_W'(flips_s1)) : '0;
		end else if (fc_q >= lim) begin
			flip_fc = fc_q;
		end else begin
			flip_fc = (flip_sum > SUM_W'(lim)) ? lim : flip_sum[CNT_W-1:0];
		end
	end

	assign wreq.word    = rd_data;
	assign wreq.lo      = p_q[BIT_W-1:0];
	assign wreq.hi_excl = same_word ? {(end_q[BIT_W-1:0] == '0), end_q[BIT_W-1:0]} :
		(BIT_W+1)'(WORD_W);
	assign wreq.set     = (act_q != ACT_FREE) && (act_q != ACT_MARK_FREE);

	bpa_word_unit u_word (
		.req (wreq),
		.res (wres)
	);

	bpa_bitmap_ram #(
		.DEPTH (WORDS),
		.AW    (WIDX)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (p_d[BIT_W +: WIDX]),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d     = state_q;
		p_d         = p_q;
		end_d       = end_q;
		run_d       = run_q;
		rs_d        = rs_q;
		fc_d        = fc_q;
		res_ok_d    = res_ok_q;
		res_start_d = res_start_q;
		init_d      = init_q;
		wr_en       = 1'b0;
		wr_addr     = p_q[BIT_W +: WIDX];
		wr_data     = wres.new_word;
		load_out    = 1'b0;
		flips_v_d   = 1'b0;
		found       = 1'b0;
		found_st    = st;
		if (flips_v_s1) begin
			fc_d = flip_fc;
		end
		unique case (state_q)
			S_INIT: begin
				wr_en   = 1'b1;
				wr_addr = init_q;
				wr_data = {WORD_W{1'b1}};
				init_d  = init_q + WIDX'(1);
				if (init_q == WIDX'(WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				res_ok_d    = 1'b0;
				res_start_d = '0;
				state_d     = S_START;
			end
			S_START: begin
				unique case (act_q) inside
					ACT_ALLOC: begin
						if (cnt_q == '0) begin
							state_d = S_DONE;
						end else begin
							p_d     = '0;
							run_d   = '0;
							rs_d    = '0;
							state_d = S_SCAN;
						end
					end
					ACT_FREE: begin
						if (addr_q == '0 || cnt_q == '0) begin
							state_d = S_DONE;
						end else begin
							res_ok_d = 1'b1;
							fc_d     = (fc_add > SUM_W'(lim)) ? lim : fc_add[CNT_W-1:0];
							if (first_pg < ADDR_W'(lim)) begin
								p_d     = first_pg[CNT_W-1:0];
								end_d   = free_end;
								state_d = S_WALK;
							end else begin
								state_d = S_DONE;
							end
						end
					end
					ACT_MARK_FREE, ACT_MARK_USED: begin
						res_ok_d = 1'b1;
						if (first_pg < ADDR_W'(mark_end)) begin
							p_d     = first_pg[CNT_W-1:0];
							end_d   = mark_end;
							state_d = S_WALK;
						end else begin
							state_d = S_DONE;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SCAN: begin
				if (p_q >= lim) begin
					state_d = S_DONE;
				end else if (fits && wres.all_ones) begin
					run_d = '0;
					p_d   = p64[CNT_W-1:0];
				end else if (fits && wres.all_zeros) begin
					if (run64 >= SUM_W'(cnt_q)) begin
						found = 1'b1;
					end else begin
						run_d = run64[CNT_W-1:0];
						rs_d  = st;
						p_d   = p64[CNT_W-1:0];
					end
				end else if (!wres.bit_at_lo) begin
					if (run_q + CNT_W'(1) == cnt_q) begin
						found = 1'b1;
					end else begin
						run_d = run_q + CNT_W'(1);
						rs_d  = st;
						p_d   = p_q + CNT_W'(1);
					end
				end else begin
					run_d = '0;
					p_d   = p_q + CNT_W'(1);
				end
				if (found) begin
					rs_d        = found_st;
					p_d         = found_st;
					end_d       = found_st + cnt_q;
					fc_d        = (fc_q > cnt_q) ? (fc_q - cnt_q) : '0;
					res_ok_d    = 1'b1;
					res_start_d = found_st[START_W-1:0];
					state_d     = S_WALK;
				end
			end
			S_WALK: begin
				wr_en     = 1'b1;
				flips_v_d = is_mark;
				if (same_word) begin
					state_d = S_DONE;
				end else begin
					p_d = next_base;
				end
			end
			S_DONE: begin
				if (!flips_v_s1 && (!out_valid_q || !out_stall)) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= '0;
			fc_q        <= '0;
			total_q     <= LIM_MAX;
			flips_v_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			res_ok_q    <= 1'b0;
			res_start_q <= '0;
		end else begin
			state_q     <= state_d;
			init_q      <= init_d;
			fc_q        <= fc_d;
			flips_v_s1  <= flips_v_d;
			res_ok_q    <= res_ok_d;
			res_start_q <= res_start_d;
			if (cfg_valid && cfg_ready) begin
				total_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action_t'(action);
			addr_q <= address & AMASK;
			len_q  <= length & AMASK;
			cnt_q  <= req_pages;
		end
		if (state_q == S_SETUP) begin
			span_q <= SP_W'(addr_q) + SP_W'(len_q) + SP_W'(PAGE_BYTES - 1);
		end
		p_q      <= p_d;
		end_q    <= end_d;
		run_q    <= run_d;
		rs_q     <= rs_d;
		flips_s1 <= wres.flips;
		if (load_out) begin
			ok_q         <= res_ok_q;
			start_page_q <= res_start_q;
			pages_left_q <= fc_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign start_page = start_page_q;
	assign pages_left = pages_left_q;

`ifndef ASSERT_OFF
	a_fc_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= LIM_MAX)
		else $error("free count above bitmap size");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> p_q < end_q)
		else $error("walk cursor past range end");

	a_scan_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> run_q < cnt_q)
		else $error("scan run reached count without stopping");

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_SETUP)
		else $error("accepted request did not enter setup");

	a_fail_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> start_page == '0)
		else $error("failed request carries a start page");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/bpa_bitmap_ram.sv =====
// bitmap word memory, one write port and one registered read port
`default_nettype none
module bpa_bitmap_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [bpa_pkg::WORD_W-1:0] wr_data,
	input  logic [AW-1:0]              rd_addr,
	output logic [bpa_pkg::WORD_W-1:0] rd_data
);
	import bpa_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/bpa_word_unit.sv =====
// shared word unit: range mask, set or clear, flip count and word flags
`default_nettype none
module bpa_word_unit (
	input  bpa_pkg::word_req_t req,
	output bpa_pkg::word_res_t res
);
	import bpa_pkg::*;

	logic [WORD_W-1:0] low_mask;
	logic [WORD_W-1:0] high_mask;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] upd;
	logic [WORD_W-1:0] changed;
	logic [FLIP_W-1:0] acc [WORD_W];

	always_comb begin
		low_mask = {WORD_W{1'b1}} << req.lo;
		if (req.hi_excl[BIT_W]) begin
			high_mask = {WORD_W{1'b1}};
		end else begin
			high_mask = ~({WORD_W{1'b1}} << req.hi_excl[BIT_W-1:0]);
		end
		mask = low_mask & high_mask;
		upd = req.set ? (req.word | mask) : (req.word & ~mask);
		changed = req.word ^ upd;
	end

	// adder tree over the changed bits
	always_comb begin
		for (int i = 0; i < WORD_W; i++) begin
			acc[i] = FLIP_W'(changed[i]);
		end
		for (int l = 1; l < WORD_W; l = l * 2) begin
			for (int i = 0; i < WORD_W; i = i + 2 * l) begin
				acc[i] = acc[i] + acc[i+l];
			end
		end
	end

	assign res.new_word  = upd;
	assign res.flips     = acc[0];
	assign res.all_ones  = &req.word;
	assign res.all_zeros = ~|req.word;
	assign res.bit_at_lo = req.word[req.lo];

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench for the bitmap page allocator: directed and random requests checked against a predictor
`default_nettype none
module tb_top;
	import bpa_pkg::*;

	localparam int NUM_PAGES      = 65536;
	localparam int PAGE_BYTES     = 4096;
	localparam int ADDR_BITS      = 48;
	localparam int RANDOM_ITEMS   = 185;
	localparam int HOLD_CYCLES    = 400;
	localparam int END_CYCLES     = 100;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		action_t           act;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] len;
		logic [CNT_W-1:0]  count;
	} page_req_t;

	typedef struct {
		logic               ok;
		logic [START_W-1:0] start;
		logic [CNT_W-1:0]   free;
	} alloc_res_t;

	typedef struct {
		longint unsigned first;
		longint unsigned pages;
	} page_run_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	action_t             action;
	logic [ADDR_W-1:0]   address;
	logic [ADDR_W-1:0]   length;
	logic [CNT_W-1:0]    req_pages;
	logic                out_valid;
	logic                out_stall;
	logic                ok;
	logic [START_W-1:0]  start_page;
	logic [CNT_W-1:0]    pages_left;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CNT_W-1:0]    cfg_data;

	// predictor state
	bit                  page_busy [0:NUM_PAGES-1];
	longint unsigned     free_left;
	logic [CNT_W-1:0]    managed_total;
	page_run_t           granted_runs [$];
	alloc_res_t          pending_results [$];

	int                  send_idle_pct;
	int                  recv_idle_pct;
	bit                  hold_off_req;
	int                  fault_count;
	int                  quiet_cycles;
	int                  reqs_sent;
	int                  results_checked;
	int                  limits_used;

	bitmap_page_allocator_unit #(
		.NUM_PAGES(NUM_PAGES),
		.PAGE_BYTES(PAGE_BYTES),
		.ADDR_BITS(ADDR_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.address(address),
		.length(length),
		.req_pages(req_pages),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok(ok),
		.start_page(start_page),
		.pages_left(pages_left),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void log_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
	endfunction

	function automatic page_req_t mk_req(input action_t a, input logic [ADDR_W-1:0] addr,
			input logic [ADDR_W-1:0] len, input logic [CNT_W-1:0] cnt);
		page_req_t r;
		r.act = a;
		r.addr = addr;
		r.len = len;
		r.count = cnt;
		return r;
	endfunction

	function automatic longint unsigned page_limit();
		return (managed_total > CNT_W'(NUM_PAGES)) ? longint'(NUM_PAGES) :
			longint'(managed_total);
	endfunction

	// updates the bitmap and free count, returns the response the block should give
	function automatic alloc_res_t apply_page_request(input page_req_t r);
		alloc_res_t      res;
		longint unsigned lim, cnt, addr, len, p, q, first, stop, run, hole_base, sum;
		bit              mark_used;
		page_run_t       g;
		lim = page_limit();
		cnt = 64'(r.count);
		addr = 64'(r.addr);
		len = 64'(r.len);
		res.ok = 1'b0;
		res.start = '0;
		run = 0;
		hole_base = 0;
		case (r.act)
			ACT_ALLOC: begin
				if (cnt != 0) begin
					for (p = 0; p < lim; p++) begin
						if (page_busy[p]) begin
							run = 0;
						end else begin
							if (run == 0) hole_base = p;
							run++;
							if (run == cnt) break;
						end
					end
				end
				if (cnt != 0 && run == cnt) begin
					for (q = hole_base; q < hole_base + cnt; q++) page_busy[q] = 1'b1;
					free_left = (free_left > cnt) ? free_left - cnt : 0;
					res.ok = 1'b1;
					res.start = hole_base[START_W-1:0];
					g.first = hole_base;
					g.pages = cnt;
					granted_runs.push_back(g);
				end
			end
			ACT_FREE: begin
				if (addr != 0 && cnt != 0) begin
					first = addr / PAGE_BYTES;
					for (p = first; p < first + cnt && p < lim; p++) page_busy[p] = 1'b0;
					sum = free_left + cnt;
					free_left = (sum > lim) ? lim : sum;
					res.ok = 1'b1;
				end
			end
			ACT_MARK_FREE, ACT_MARK_USED: begin
				mark_used = (r.act == ACT_MARK_USED);
				stop = (addr + len + PAGE_BYTES - 1) / PAGE_BYTES;
				for (p = addr / PAGE_BYTES; p < stop && p < lim; p++) begin
					if (page_busy[p] != mark_used) begin
						page_busy[p] = mark_used;
						if (mark_used) begin
							if (free_left > 0) free_left--;
						end else if (free_left < lim) begin
							free_left++;
						end
					end
				end
				res.ok = 1'b1;
			end
		endcase
		res.free = free_left[CNT_W-1:0];
		return res;
	endfunction

	// mostly well-formed traffic inside the managed range, some full-width noise
	function automatic page_req_t draw_request();
		page_req_t   r;
		int unsigned pick, page, k;
		pick = $urandom_range(0, 99);
		page = $urandom_range(0, int'(page_limit()) + 8);
		r.act = ACT_ALLOC;
		r.addr = ADDR_W'(longint'(page) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
		r.len = ADDR_W'($urandom_range(0, 40 * PAGE_BYTES));
		r.count = CNT_W'($urandom_range(1, 16));
		if (pick < 10) begin
			r.act = action_t'($urandom_range(0, 3));
			r.addr = {16'($urandom), 32'($urandom)};
			r.len = {16'($urandom), 32'($urandom)};
			r.count = CNT_W'($urandom_range(0, NUM_PAGES));
		end else if (pick < 45) begin
			if ($urandom_range(0, 39) == 0) r.count = '0;
			else if ($urandom_range(0, 7) == 0) r.count = CNT_W'($urandom_range(17, 96));
			else r.count = CNT_W'($urandom_range(1, 12));
		end else if (pick < 75) begin
			r.act = ACT_FREE;
			if (granted_runs.size() != 0 && $urandom_range(0, 4) != 0) begin
				k = $urandom_range(0, granted_runs.size() - 1);
				r.addr = ADDR_W'(granted_runs[k].first * PAGE_BYTES +
					$urandom_range(0, PAGE_BYTES - 1));
				r.count = CNT_W'(granted_runs[k].pages);
				granted_runs.delete(k);
			end
		end else if (pick < 90) begin
			r.act = ACT_MARK_FREE;
		end else begin
			r.act = ACT_MARK_USED;
		end
		return r;
	endfunction

	task automatic issue_request(input page_req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= r.act;
		address <= r.addr;
		length <= r.len;
		req_pages <= r.count;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(apply_page_request(r));
		reqs_sent++;
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_page_limit(input logic [CNT_W-1:0] value);
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		managed_total = value;
		limits_used++;
	endtask

	// everything is used after reset, so nothing can be allocated yet
	task automatic test_after_reset();
		issue_request(mk_req(ACT_ALLOC, '0, '0, 17'd1));
		issue_request(mk_req(ACT_ALLOC, '0, '0, '0));
		issue_request(mk_req(ACT_FREE, '0, '0, 17'd5));
		issue_request(mk_req(ACT_FREE, 48'd4096, '0, '0));
	endtask

	task automatic test_small_map();
		write_page_limit(17'd64);
		issue_request(mk_req(ACT_MARK_FREE, '0, 48'(64 * PAGE_BYTES), '0));
		issue_request(mk_req(ACT_ALLOC, '0, '0, 17'd64));
		issue_request(mk_req(ACT_FREE, 48'd1, '0, 17'd64));
		issue_request(mk_req(ACT_ALLOC, '0, '0, 17'd65));
		issue_request(mk_req(ACT_ALLOC, '0, '0, 17'd3));
		issue_request(mk_req(ACT_MARK_USED, 48'(3 * PAGE_BYTES), 48'(PAGE_BYTES), '0));
		issue_request(mk_req(ACT_ALLOC, '0, '0, 17'd1));
		issue_request(mk_req(ACT_MARK_USED, '0, '0, '0));
		issue_request(mk_req(ACT_MARK_FREE, 48'd1, '0, '0));
		issue_request(mk_req(ACT_FREE, 48'(60 * PAGE_BYTES), '0, 17'd10));
		issue_request(mk_req(ACT_MARK_FREE, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, '0));
		issue_request(mk_req(ACT_FREE, 48'hFFFF_FFFF_FFFF, '0, 17'h10000));
	endtask

	task automatic test_zero_limit();
		write_page_limit('0);
		issue_request(mk_req(ACT_ALLOC, '0, '0, 17'd1));
		issue_request(mk_req(ACT_FREE, 48'd4096, '0, 17'd1));
		issue_request(mk_req(ACT_MARK_FREE, '0, 48'(8 * PAGE_BYTES), '0));
	endtask

	// oversized limit acts as the full map; exercises a run ending on the top page
	task automatic test_full_map();
		write_page_limit(17'h1FFFF);
		issue_request(mk_req(ACT_MARK_FREE, '0, 48'(longint'(NUM_PAGES) * PAGE_BYTES), '0));
		issue_request(mk_req(ACT_ALLOC, '0, '0, 17'h10000));
		issue_request(mk_req(ACT_FREE, 48'(longint'(NUM_PAGES - 1) * PAGE_BYTES), '0, 17'd1));
		issue_request(mk_req(ACT_ALLOC, '0, '0, 17'd1));
		write_page_limit(17'h10000);
		issue_request(mk_req(ACT_ALLOC, '0, '0, 17'd2));
		issue_request(mk_req(ACT_MARK_FREE, '0, 48'(128 * PAGE_BYTES), '0));
	endtask

	task automatic test_random_traffic(input logic [CNT_W-1:0] limit, input int send_pct,
			input int recv_pct);
		int k;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_page_limit(limit);
		granted_runs.delete();
		issue_request(mk_req(ACT_MARK_FREE, '0, 48'(longint'(limit) * PAGE_BYTES), '0));
		for (k = 0; k < RANDOM_ITEMS; k++) issue_request(draw_request());
	endtask

	// receiver holds off long enough for the block to back up and stall its input
	task automatic test_output_holdoff();
		int k;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_page_limit(17'd128);
		hold_off_req = 1'b1;
		for (k = 0; k < 10; k++) issue_request(draw_request());
		wait_results_drained();
	endtask

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		alloc_res_t want;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				log_fault($sformatf("result with nothing pending: ok %0d start %0d free %0d",
					ok, start_page, pages_left));
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (ok !== want.ok)
					log_fault($sformatf("ok expected %0d got %0d", want.ok, ok));
				if (start_page !== want.start)
					log_fault($sformatf("start_page expected %0d got %0d", want.start, start_page));
				if (pages_left !== want.free)
					log_fault($sformatf("pages_left expected %0d got %0d", want.free, pages_left));
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		in_valid <= 1'b0;
		action <= ACT_ALLOC;
		address <= '0;
		length <= '0;
		req_pages <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		quiet_cycles = 0;
		fault_count = 0;
		hold_off_req = 1'b0;
		foreach (page_busy[i]) page_busy[i] = 1'b1;
		free_left = 0;
		managed_total = 17'h10000;
		send_idle_pct = 27;
		recv_idle_pct = 72;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_after_reset();
		test_small_map();
		test_zero_limit();
		test_full_map();
		test_random_traffic(17'd200, 27, 72);
		test_random_traffic(17'($urandom_range(600, 1400)), 72, 27);
		test_random_traffic(17'($urandom_range(2000, 4096)), 0, 0);
		test_output_holdoff();
		wait_results_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			log_fault($sformatf("%0d results never arrived", pending_results.size()));
		$display("ran %0d requests over %0d page limit settings, %0d responses checked",
			reqs_sent, limits_used, results_checked);
		$display("allocate, free and mark traffic under both idling patterns and a long output hold");
		if (fault_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
`default_nettype wire
